>>> sv/assert_macros.svh
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define PRA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define PRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> sv/pra_pkg.sv
`default_nettype none

package pra_pkg;

  // Field widths
  localparam int COORD_W      = 16;
  localparam int ANGLE_FRAC   = 8;
  localparam int TURN_W       = 18;
  localparam int HEADING_W    = 19;

  // Angles, in 2^-ANGLE_FRAC degree
  localparam int FULL_TURN    = 360 << ANGLE_FRAC;
  localparam int QUARTER_TURN = 90 << ANGLE_FRAC;
  localparam int ERR_W        = $clog2(FULL_TURN);
  localparam int R_W          = $clog2(QUARTER_TURN);
  localparam int SUM_W        = TURN_W + 2;

  // CORDIC: angles in 2^-24 degree, x/y in Q2.30
  localparam int CORDIC_STEPS = 16;
  localparam int MAX_STEPS    = 24;
  localparam int CORDIC_FRAC  = 24;
  localparam int Z_SHIFT      = CORDIC_FRAC - ANGLE_FRAC;
  localparam int CW           = 33;
  localparam int CORDIC_X0    = 652032874;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W   = $clog2(MAX_STEPS);

  // Q1.15 factors and the rotate/accumulate path
  localparam int FRAC_Q15     = 15;
  localparam int UNIT_Q15     = 1 << FRAC_Q15;
  localparam int HALF_Q15     = 1 << (FRAC_Q15 - 1);
  localparam int FACT_W       = FRAC_Q15 + 2;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = DIFF_W + FACT_W;
  localparam int ACC_W        = PROD_W + 2;
  localparam int RND_W        = ACC_W - FRAC_Q15;

  // Stream payload widths, padded to whole bytes
  localparam int S_TDATA_W    = ((2 * COORD_W + TURN_W + 7) / 8) * 8;
  localparam int M_TDATA_W    = ((2 * COORD_W + HEADING_W + 7) / 8) * 8;

  // Register map
  localparam int CFG_ADDR_W   = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_PIVOT_X = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_PIVOT_Y = 1'b1;

  // Multiplier phases
  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_DX_CC = 3'd0;
  localparam logic [PH_W-1:0] PH_DY_SS = 3'd1;
  localparam logic [PH_W-1:0] PH_DX_SS = 3'd2;
  localparam logic [PH_W-1:0] PH_DY_CC = 3'd3;
  localparam logic [PH_W-1:0] PH_FLUSH = 3'd4;

  typedef struct packed {
    logic              load;
    logic              prep;
    logic              step;
    logic [STEP_W-1:0] step_idx;
    logic              trig;
    logic              mul;
    logic [PH_W-1:0]   mul_phase;
    logic              round;
    logic              finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // atan(2^-i) in 2^-24 degree
  function automatic logic signed [CW-1:0] atan_angle(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [CW-1:0] a;
    case (idx)
      5'd0:  a = CW'(754974720);
      5'd1:  a = CW'(445687602);
      5'd2:  a = CW'(235489088);
      5'd3:  a = CW'(119537938);
      5'd4:  a = CW'(60000934);
      5'd5:  a = CW'(30029717);
      5'd6:  a = CW'(15018523);
      5'd7:  a = CW'(7509720);
      5'd8:  a = CW'(3754917);
      5'd9:  a = CW'(1877466);
      5'd10: a = CW'(938734);
      5'd11: a = CW'(469367);
      5'd12: a = CW'(234684);
      5'd13: a = CW'(117342);
      5'd14: a = CW'(58671);
      5'd15: a = CW'(29335);
      5'd16: a = CW'(14668);
      5'd17: a = CW'(7334);
      5'd18: a = CW'(3667);
      5'd19: a = CW'(1833);
      5'd20: a = CW'(917);
      5'd21: a = CW'(458);
      5'd22: a = CW'(229);
      5'd23: a = CW'(115);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> sv/pra_ctrl.sv
`default_nettype none

module pra_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pra_pkg::status_t status_i,
  output pra_pkg::cmd_t    cmd_o
);
  import pra_pkg::*;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] ST_PREP   = 3'd1;
  localparam logic [ST_W-1:0] ST_CORDIC = 3'd2;
  localparam logic [ST_W-1:0] ST_TRIG   = 3'd3;
  localparam logic [ST_W-1:0] ST_MUL    = 3'd4;
  localparam logic [ST_W-1:0] ST_ROUND  = 3'd5;
  localparam logic [ST_W-1:0] ST_FINISH = 3'd6;

  logic [ST_W-1:0]   state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [PH_W-1:0]   mul_q, mul_d;

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    mul_d        = mul_q;
    cmd_o        = '0;
    cmd_o.step_idx  = step_q;
    cmd_o.mul_phase = mul_q;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        step_d     = '0;
        state_d    = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd_o.step = 1'b1;
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
          state_d = ST_TRIG;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_TRIG: begin
        cmd_o.trig = 1'b1;
        mul_d      = PH_DX_CC;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        case (mul_q)
          PH_DX_CC: mul_d = PH_DY_SS;
          PH_DY_SS: mul_d = PH_DX_SS;
          PH_DX_SS: mul_d = PH_DY_CC;
          PH_DY_CC: mul_d = PH_FLUSH;
          default:  state_d = ST_ROUND;
        endcase
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = ST_FINISH;
      end
      ST_FINISH: begin
        // hold here while the previous result is still unclaimed
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      mul_q   <= PH_DX_CC;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      mul_q   <= mul_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/pra_datapath.sv
`default_nettype none

module pra_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pra_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [pra_pkg::COORD_W-1:0]       cfg_wdata_i,
  input  logic [pra_pkg::S_TDATA_W-1:0]     in_data_i,
  input  logic                              in_last_i,
  input  pra_pkg::cmd_t                     cmd_i,
  output pra_pkg::status_t                  status_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [pra_pkg::M_TDATA_W-1:0]     out_data_o,
  output logic                              out_user_o
);
  import pra_pkg::*;

  localparam logic signed [TURN_W-1:0]    TURN_POS  = TURN_W'(FULL_TURN);
  localparam logic signed [TURN_W-1:0]    TURN_NEG  = TURN_W'(-FULL_TURN);
  localparam logic signed [SUM_W-1:0]     FULL_S    = SUM_W'(FULL_TURN);
  localparam logic [ERR_W-1:0]            QTR_1     = ERR_W'(QUARTER_TURN);
  localparam logic [ERR_W-1:0]            QTR_2     = ERR_W'(2 * QUARTER_TURN);
  localparam logic [ERR_W-1:0]            QTR_3     = ERR_W'(3 * QUARTER_TURN);
  localparam logic signed [CW-1:0]        X0_C      = CW'(CORDIC_X0);
  localparam logic signed [CW-1:0]        UNIT_C    = CW'(UNIT_Q15);
  localparam logic signed [CW-1:0]        NUNIT_C   = CW'(-UNIT_Q15);
  localparam logic signed [CW-1:0]        C_HALF    = CW'(HALF_Q15);
  localparam logic signed [CW-1:0]        C_HALF_LO = CW'(HALF_Q15 - 1);
  localparam logic signed [ACC_W-1:0]     A_HALF    = ACC_W'(HALF_Q15);
  localparam logic signed [ACC_W-1:0]     A_HALF_LO = ACC_W'(HALF_Q15 - 1);
  localparam logic signed [COORD_W-1:0]   CMAX      = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0]   CMIN      = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [HEADING_W:0]   FULL_H    = (HEADING_W+1)'(FULL_TURN);
  localparam int                          PAD_W     = M_TDATA_W - 2 * COORD_W - HEADING_W;
  localparam logic [1:0] QD_0 = 2'd0;
  localparam logic [1:0] QD_1 = 2'd1;
  localparam logic [1:0] QD_2 = 2'd2;

  // configuration and architectural state
  logic signed [COORD_W-1:0]   pivot_x_q, pivot_y_q;
  logic [ERR_W-1:0]            err_q, err_d;
  logic signed [HEADING_W-1:0] head_q, head_d;
  logic                        out_valid_q;

  // item payload
  logic signed [COORD_W-1:0]   px_q, py_q;
  logic signed [TURN_W-1:0]    turn_q;
  logic                        last_q;
  logic [ERR_W-1:0]            total_q;
  logic [1:0]                  quad_q;
  logic                        rzero_q;
  logic signed [CW-1:0]        x_q, y_q, z_q;
  logic signed [FACT_W-1:0]    cc_q, ss_q;
  logic signed [DIFF_W-1:0]    dx_q, dy_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]     accx_q, accy_q;
  logic signed [RND_W-1:0]     rx_q, ry_q;
  logic signed [COORD_W-1:0]   ox_q, oy_q;
  logic signed [HEADING_W-1:0] ohead_q;
  logic                        ounmoved_q;

  // combinational next values
  logic signed [COORD_W-1:0]   in_px, in_py;
  logic signed [TURN_W-1:0]    in_turn, turn_sat;
  logic signed [SUM_W-1:0]     sum_raw, sum_wrap;
  logic [ERR_W-1:0]            total_d;
  logic [1:0]                  quad_d;
  logic [R_W-1:0]              r_d;
  logic signed [CW-1:0]        xs, ys, at, x_n, y_n, z_n;
  logic signed [CW-1:0]        xr, yr;
  logic signed [FACT_W-1:0]    c_f, s_f, cc_d, ss_d;
  logic signed [DIFF_W-1:0]    op_a;
  logic signed [FACT_W-1:0]    op_b;
  logic signed [ACC_W-1:0]     rxs, rys;
  logic                        same;
  logic signed [COORD_W-1:0]   ox_d, oy_d;
  logic signed [HEADING_W:0]   hc;

  assign in_px   = in_data_i[COORD_W-1:0];
  assign in_py   = in_data_i[2*COORD_W-1:COORD_W];
  assign in_turn = in_data_i[2*COORD_W+TURN_W-1:2*COORD_W];

  always_comb begin
    if (in_turn > TURN_POS) begin
      turn_sat = TURN_POS;
    end else if (in_turn < TURN_NEG) begin
      turn_sat = TURN_NEG;
    end else begin
      turn_sat = in_turn;
    end
  end

  // total angle, wrapped once into one turn, then split into quadrant + rest
  always_comb begin
    sum_raw = SUM_W'(turn_q) + SUM_W'($signed({1'b0, err_q}));
    if (sum_raw < 0) begin
      sum_wrap = sum_raw + FULL_S;
    end else if (sum_raw >= FULL_S) begin
      sum_wrap = sum_raw - FULL_S;
    end else begin
      sum_wrap = sum_raw;
    end
    total_d = ERR_W'(sum_wrap);
    if (total_d >= QTR_3) begin
      quad_d = 2'd3;
      r_d    = R_W'(total_d - QTR_3);
    end else if (total_d >= QTR_2) begin
      quad_d = 2'd2;
      r_d    = R_W'(total_d - QTR_2);
    end else if (total_d >= QTR_1) begin
      quad_d = 2'd1;
      r_d    = R_W'(total_d - QTR_1);
    end else begin
      quad_d = 2'd0;
      r_d    = R_W'(total_d);
    end
  end

  // one CORDIC micro-rotation
  always_comb begin
    xs = x_q >>> cmd_i.step_idx;
    ys = y_q >>> cmd_i.step_idx;
    at = atan_angle(ATAN_IDX_W'(cmd_i.step_idx));
    if (!z_q[CW-1]) begin
      x_n = x_q - ys;
      y_n = y_q + xs;
      z_n = z_q - at;
    end else begin
      x_n = x_q + ys;
      y_n = y_q - xs;
      z_n = z_q + at;
    end
  end

  // CORDIC result to Q1.15, clamped to +-1.0, then quadrant fold
  always_comb begin
    xr = (x_q + (x_q[CW-1] ? C_HALF_LO : C_HALF)) >>> FRAC_Q15;
    yr = (y_q + (y_q[CW-1] ? C_HALF_LO : C_HALF)) >>> FRAC_Q15;
    if (rzero_q) begin
      c_f = FACT_W'(UNIT_Q15);
      s_f = '0;
    end else begin
      if (xr > UNIT_C) begin
        c_f = FACT_W'(UNIT_C);
      end else if (xr < NUNIT_C) begin
        c_f = FACT_W'(NUNIT_C);
      end else begin
        c_f = FACT_W'(xr);
      end
      if (yr > UNIT_C) begin
        s_f = FACT_W'(UNIT_C);
      end else if (yr < NUNIT_C) begin
        s_f = FACT_W'(NUNIT_C);
      end else begin
        s_f = FACT_W'(yr);
      end
    end
    case (quad_q)
      QD_0: begin
        cc_d = c_f;
        ss_d = s_f;
      end
      QD_1: begin
        cc_d = -s_f;
        ss_d = c_f;
      end
      QD_2: begin
        cc_d = -c_f;
        ss_d = -s_f;
      end
      default: begin
        cc_d = s_f;
        ss_d = -c_f;
      end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    case (cmd_i.mul_phase)
      PH_DX_CC: begin
        op_a = dx_q;
        op_b = cc_q;
      end
      PH_DY_SS: begin
        op_a = dy_q;
        op_b = ss_q;
      end
      PH_DX_SS: begin
        op_a = dx_q;
        op_b = ss_q;
      end
      PH_DY_CC: begin
        op_a = dy_q;
        op_b = cc_q;
      end
      default: begin
        op_a = dx_q;
        op_b = cc_q;
      end
    endcase
  end

  // round half away from zero by 15 bits
  assign rxs = accx_q + (accx_q[ACC_W-1] ? A_HALF_LO : A_HALF);
  assign rys = accy_q + (accy_q[ACC_W-1] ? A_HALF_LO : A_HALF);

  // wrap-up: compare before saturation, heading wrap, error update
  always_comb begin
    same = (rx_q == RND_W'(px_q)) && (ry_q == RND_W'(py_q));
    if (rx_q > RND_W'(CMAX)) begin
      ox_d = CMAX;
    end else if (rx_q < RND_W'(CMIN)) begin
      ox_d = CMIN;
    end else begin
      ox_d = COORD_W'(rx_q);
    end
    if (ry_q > RND_W'(CMAX)) begin
      oy_d = CMAX;
    end else if (ry_q < RND_W'(CMIN)) begin
      oy_d = CMIN;
    end else begin
      oy_d = COORD_W'(ry_q);
    end
    hc = (HEADING_W+1)'(head_q);
    if (hc > FULL_H) begin
      hc = hc - FULL_H;
    end else if (hc < 0) begin
      hc = hc + FULL_H;
    end
    if (last_q) begin
      hc = hc + (HEADING_W+1)'(turn_q);
    end
    head_d = HEADING_W'(hc);
    // wrapped err + turn was already formed as the total angle
    err_d  = same ? total_q : err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_x_q <= '0;
      pivot_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_PIVOT_X: pivot_x_q <= cfg_wdata_i;
        REG_PIVOT_Y: pivot_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q       <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      err_q       <= err_d;
      head_q      <= head_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q   <= in_px;
      py_q   <= in_py;
      turn_q <= turn_sat;
      last_q <= in_last_i;
    end
    if (cmd_i.prep) begin
      total_q <= total_d;
      quad_q  <= quad_d;
      rzero_q <= (r_d == '0);
      x_q     <= X0_C;
      y_q     <= '0;
      z_q     <= $signed(CW'({r_d, {Z_SHIFT{1'b0}}}));
    end else if (cmd_i.step) begin
      x_q <= x_n;
      y_q <= y_n;
      z_q <= z_n;
    end
    if (cmd_i.trig) begin
      cc_q   <= cc_d;
      ss_q   <= ss_d;
      dx_q   <= DIFF_W'(px_q) - DIFF_W'(pivot_x_q);
      dy_q   <= DIFF_W'(py_q) - DIFF_W'(pivot_y_q);
      accx_q <= ACC_W'(pivot_x_q) <<< FRAC_Q15;
      accy_q <= ACC_W'(pivot_y_q) <<< FRAC_Q15;
    end
    if (cmd_i.mul) begin
      prod_q <= op_a * op_b;
      // accumulate the product formed in the previous phase
      case (cmd_i.mul_phase)
        PH_DY_SS: accx_q <= accx_q + ACC_W'(prod_q);
        PH_DX_SS: accx_q <= accx_q - ACC_W'(prod_q);
        PH_DY_CC: accy_q <= accy_q + ACC_W'(prod_q);
        PH_FLUSH: accy_q <= accy_q + ACC_W'(prod_q);
        default: ;
      endcase
    end
    if (cmd_i.round) begin
      rx_q <= RND_W'(rxs >>> FRAC_Q15);
      ry_q <= RND_W'(rys >>> FRAC_Q15);
    end
    if (cmd_i.finish) begin
      ox_q       <= ox_d;
      oy_q       <= oy_d;
      ohead_q    <= head_d;
      ounmoved_q <= same;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = {{PAD_W{1'b0}}, ohead_q, oy_q, ox_q};
  assign out_user_o        = ounmoved_q;

endmodule

`default_nettype wire

>>> sv/point_rotator_about_origin_unit.sv
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tdata: point_x, point_y, turn_angle; tlast: last_in_set
// m_axis    out  tvalid/tready         tdata: rotated_x, rotated_y, heading_now; tuser: unmoved
// cfg       in   cfg_we_i (no stall)   cfg_addr_i: 0 pivot_x, 1 pivot_y; cfg_wdata_i
//
// A new request is taken only after the previous one has passed all its steps:
// the CORDIC shift-add unit runs its iterations one after another, and the four
// products share one 17x17 multiplier.
// A finished result waits in the output register; the next request is taken
// meanwhile, and the unit only holds in its last step if the old one is unclaimed.
// Reset (async, active low) clears pivot, error angle, heading and handshake state.
`default_nettype none
`include "assert_macros.svh"

module point_rotator_about_origin_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] point_x, [31:16] point_y, [49:32] turn_angle, rest zero
  input  logic [pra_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] rotated_x, [31:16] rotated_y, [50:32] heading_now, rest zero
  output logic [pra_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // [0] unmoved
  output logic                           m_axis_tuser,
  input  logic                           cfg_we_i,
  input  logic [pra_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [pra_pkg::COORD_W-1:0]    cfg_wdata_i
);
  import pra_pkg::*;

  cmd_t    cmd;
  status_t status;

  pra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pra_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

  `PRA_ASSERT_NEXT(a_load_starts_prep, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, cmd.prep)
  `PRA_ASSERT_IMPL(a_idle_no_work, clk_i, rst_ni, s_axis_tready, !(cmd.step || cmd.mul || cmd.round))
  `PRA_ASSERT_IMPL(a_finish_needs_slot, clk_i, rst_ni, cmd.finish, status.out_free)
  `PRA_ASSERT_IMPL(a_valid_from_finish, clk_i, rst_ni, $rose(m_axis_tvalid), $past(cmd.finish))

endmodule

`default_nettype wire
